// ===== src/lsqt_pkg.sv =====
// shared types, constants and time arithmetic for the load/store queue timing block
`timescale 1ns / 1ps
package lsqt_pkg;

	localparam int unsigned TimeW      = 63;
	localparam int unsigned LatW       = 32;
	localparam int unsigned AddrW      = 64;
	localparam int unsigned CycW       = 20;
	localparam int unsigned CfgIdxW    = 2;
	localparam int unsigned InDataW    = 160;
	localparam int unsigned OutDataW   = 128;
	localparam int unsigned LoadDepth  = 8;
	localparam int unsigned StoreDepth = 8;

	localparam logic [CycW-1:0] CycleTimeReset = CycW'(1000);

	typedef logic [TimeW-1:0] lsqt_time_t;
	typedef logic [AddrW-1:0] lsqt_addr_t;

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_SPEC_LOADS = 2'd0,
		REG_MULTI_RFOS = 2'd1,
		REG_CYCLE_TIME = 2'd2
	} lsqt_reg_t;

	// what a store cell compares against on a load lookup
	typedef struct packed {
		lsqt_addr_t addr;
		lsqt_time_t sched;
	} lsqt_key_t;

	// what shifts into the head of the store chain
	typedef struct packed {
		logic       shift;
		lsqt_time_t rel;
		lsqt_addr_t addr;
	} lsqt_push_t;

	// saturating add of two times
	function automatic lsqt_time_t sat_add(input lsqt_time_t a, input lsqt_time_t b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TimeW] ? '1 : s[TimeW-1:0];
	endfunction

	function automatic lsqt_time_t tmax(input lsqt_time_t a, input lsqt_time_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== src/lsqt_lcell.sv =====
// one load queue cell: holds a release time and hands it on when the chain shifts
`timescale 1ns / 1ps
module lsqt_lcell
	import lsqt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  lsqt_time_t rel_in,
	output lsqt_time_t rel
);

	lsqt_time_t rel_q;

	// release time, taken from the neighbour on each allocation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q <= '0;
		end else if (shift) begin
			rel_q <= rel_in;
		end
	end

	assign rel = rel_q;

endmodule

// ===== src/lsqt_scell.sv =====
// one store queue cell: release time, address and valid, plus its forwarding compare
`timescale 1ns / 1ps
module lsqt_scell
	import lsqt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  lsqt_time_t rel_in,
	input  lsqt_addr_t addr_in,
	input  logic       valid_in,
	input  lsqt_key_t  key,
	output lsqt_time_t rel,
	output lsqt_addr_t addr,
	output logic       valid,
	output logic       hit
);

	lsqt_time_t rel_q;
	lsqt_addr_t addr_q;
	logic       valid_q;

	// control and release time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q   <= '0;
			valid_q <= 1'b0;
		end else if (shift) begin
			rel_q   <= rel_in;
			valid_q <= valid_in;
		end
	end

	// address payload
	always_ff @(posedge clk) begin
		if (shift) begin
			addr_q <= addr_in;
		end
	end

	// same address and not yet released at the load's schedule time
	assign hit   = valid_q && (addr_q == key.addr) && (rel_q >= key.sched);
	assign rel   = rel_q;
	assign addr  = addr_q;
	assign valid = valid_q;

endmodule

// ===== src/load_store_queue_timing.sv =====
// load/store queue timing block: cell chains for both queues, lookup and commit steps
// an item is registered on accept and moves to the result register once the output is free
// one item at a time: the next item is accepted once the last one commits; lookup across
// the store chain, then the release time sum and the shift of the chain taking the entry
// a stalled result does not block the next accept, only the following commit
// reset clears all release times, store valid bits and configuration to defaults
`timescale 1ns / 1ps
module load_store_queue_timing
	import lsqt_pkg::*;
#(
	parameter int unsigned LOAD_ENTRIES  = LoadDepth,
	parameter int unsigned STORE_ENTRIES = StoreDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// sched_at, access_latency, address, zero fill
	input  logic [InDataW-1:0]  s_axis_tdata,
	// operation
	input  logic                s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// alloc_at, ready_time, zero fill
	output logic [OutDataW-1:0] m_axis_tdata,
	// forwarded
	output logic                m_axis_tuser,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CycW-1:0]     cfg_wdata
);

	// configuration
	logic            spec_q;
	logic            mrfo_q;
	logic [CycW-1:0] cyc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_q <= 1'b0;
			mrfo_q <= 1'b0;
			cyc_q  <= CycleTimeReset;
		end else if (cfg_we) begin
			case (lsqt_reg_t'(cfg_index))
				REG_SPEC_LOADS: spec_q <= cfg_wdata[0];
				REG_MULTI_RFOS: mrfo_q <= cfg_wdata[0];
				REG_CYCLE_TIME: cyc_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input fields
	lsqt_time_t in_sched;
	logic [LatW-1:0] in_lat;
	lsqt_addr_t in_addr;
	logic in_store;
	lsqt_time_t cyc_t;

	assign in_sched = s_axis_tdata[TimeW-1:0];
	assign in_lat   = s_axis_tdata[TimeW+LatW-1:TimeW];
	assign in_addr  = s_axis_tdata[TimeW+LatW+AddrW-1:TimeW+LatW];
	assign in_store = s_axis_tuser;
	assign cyc_t    = TimeW'(cyc_q);

	// chains
	lsqt_time_t l_rel [LOAD_ENTRIES];
	lsqt_time_t s_rel [STORE_ENTRIES];
	lsqt_addr_t s_addr [STORE_ENTRIES];
	logic [STORE_ENTRIES-1:0] s_valid;
	logic [STORE_ENTRIES-1:0] s_hit;
	logic l_shift;
	lsqt_time_t l_new;
	lsqt_push_t s_push;
	lsqt_key_t key;

	assign key.addr  = in_addr;
	assign key.sched = in_sched;

	genvar gi;
	generate
		for (gi = 0; gi < LOAD_ENTRIES; gi++) begin : g_lcell
			lsqt_lcell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (l_shift),
				.rel_in ((gi == 0) ? l_new : l_rel[(gi == 0) ? 0 : gi-1]),
				.rel    (l_rel[gi])
			);
		end
		for (gi = 0; gi < STORE_ENTRIES; gi++) begin : g_scell
			lsqt_scell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (s_push.shift),
				.rel_in   ((gi == 0) ? s_push.rel : s_rel[(gi == 0) ? 0 : gi-1]),
				.addr_in  ((gi == 0) ? s_push.addr : s_addr[(gi == 0) ? 0 : gi-1]),
				.valid_in ((gi == 0) ? 1'b1 : s_valid[(gi == 0) ? 0 : gi-1]),
				.key      (key),
				.rel      (s_rel[gi]),
				.addr     (s_addr[gi]),
				.valid    (s_valid[gi]),
				.hit      (s_hit[gi])
			);
		end
	endgenerate

	// head of a chain is the newest entry, tail the slot to be reused
	lsqt_time_t l_newest, l_oldest, s_newest, s_oldest;
	assign l_newest = l_rel[0];
	assign l_oldest = l_rel[LOAD_ENTRIES-1];
	assign s_newest = s_rel[0];
	assign s_oldest = s_rel[STORE_ENTRIES-1];

	// lookup step, done as the item is accepted
	logic       in_fire;
	logic       lk_hit;
	lsqt_time_t lk_lat, lk_alloc, lk_fwd_ready, lk_inc, lk_base;
	logic       lk_mode;

	always_comb begin
		lk_hit       = !in_store && (|s_hit);
		lk_lat       = sat_add(TimeW'(in_lat), cyc_t);
		lk_fwd_ready = sat_add(in_sched, cyc_t);
		if (in_store) begin
			lk_alloc = tmax(s_oldest, in_sched);
			lk_inc   = tmax(sat_add(s_newest, cyc_t), l_newest);
			lk_base  = tmax(tmax(in_sched, s_newest), l_newest);
			lk_mode  = mrfo_q;
		end else begin
			lk_alloc = lk_hit ? in_sched : tmax(l_oldest, in_sched);
			lk_inc   = sat_add(l_newest, cyc_t);
			lk_base  = tmax(l_newest, in_sched);
			lk_mode  = spec_q;
		end
	end

	logic       busy_s1;
	logic       store_s1, hit_s1, mode_s1;
	lsqt_time_t lat_s1, alloc_s1, fwd_ready_s1, inc_s1, base_s1;
	lsqt_addr_t addr_s1;
	logic       commit;

	assign s_axis_tready = !busy_s1;
	assign in_fire       = s_axis_tvalid && !busy_s1;
	assign commit        = busy_s1 && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_fire) begin
			busy_s1 <= 1'b1;
		end else if (commit) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			store_s1     <= in_store;
			hit_s1       <= lk_hit;
			mode_s1      <= lk_mode;
			lat_s1       <= lk_lat;
			alloc_s1     <= lk_alloc;
			fwd_ready_s1 <= lk_fwd_ready;
			inc_s1       <= lk_inc;
			base_s1      <= lk_base;
			addr_s1      <= in_addr;
		end
	end

	// commit step: release time and ready time
	lsqt_time_t sum_alloc, sum_base, rel, ready;

	always_comb begin
		sum_alloc = sat_add(alloc_s1, lat_s1);
		sum_base  = sat_add(base_s1, lat_s1);
		rel       = mode_s1 ? tmax(sum_alloc, inc_s1) : sum_base;
		if (store_s1) begin
			ready = '0;
		end else if (hit_s1) begin
			ready = fwd_ready_s1;
		end else begin
			ready = mode_s1 ? sum_alloc : sum_base;
		end
	end

	assign l_shift      = commit && !store_s1 && !hit_s1;
	assign l_new        = rel;
	assign s_push.shift = commit && store_s1;
	assign s_push.rel   = rel;
	assign s_push.addr  = addr_s1;

	// result register
	logic       out_valid_q;
	lsqt_time_t out_alloc_q, out_ready_q;
	logic       out_fwd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_alloc_q <= alloc_s1;
			out_ready_q <= ready;
			out_fwd_q   <= hit_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OutDataW - 2 * TimeW){1'b0}}, out_ready_q, out_alloc_q};
	assign m_axis_tuser  = out_fwd_q;

endmodule

// ===== src/lsqt_checker.sv =====
// port level checks for the load/store queue timing block, bound to the top level
`timescale 1ns / 1ps
module lsqt_checker
	import lsqt_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OutDataW-1:0] m_axis_tdata,
	input logic                m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// one item in flight: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted back to back");

	// a new result only appears after an item has been at work
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result without an item at work");

	// a forwarded load is ready no earlier than it was allocated
	a_fwd_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[2*TimeW-1:TimeW] >= m_axis_tdata[TimeW-1:0])
		else $error("forwarded ready time before allocate time");

endmodule

bind load_store_queue_timing lsqt_checker u_lsqt_checker (.*);

// ===== tb/sv/tb_top.sv =====
// testbench for the load/store queue timing block: directed table, random phases, scoreboard
`timescale 1ns / 1ps
module tb_top;
	import lsqt_pkg::*;

	typedef enum bit {
		OP_LOAD  = 1'b0,
		OP_STORE = 1'b1
	} access_op_t;

	typedef enum bit {
		ROW_ACCESS = 1'b0,
		ROW_REG    = 1'b1
	} row_kind_t;

	// timing of one access as the block reports it
	typedef struct packed {
		lsqt_time_t alloc_at;
		lsqt_time_t ready_time;
		logic       forwarded;
	} access_timing_t;

	// one line of a directed table: an access or a register write
	typedef struct packed {
		row_kind_t             kind;
		access_op_t            op;
		lsqt_time_t            sched;
		logic [LatW-1:0]       lat;
		lsqt_addr_t            addr;
		logic [CfgIdxW-1:0]    reg_idx;
		logic [CycW-1:0]       reg_val;
		bit                    typed;
		access_timing_t        expected;
	} stim_row_t;

	localparam lsqt_time_t         TimeCeil  = '1;
	localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
	localparam lsqt_addr_t         AddrLow   = 64'h0;
	localparam lsqt_addr_t         AddrHigh  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam lsqt_addr_t         AddrMix   = 64'hA5A5_5A5A_0F0F_F0F0;
	localparam lsqt_addr_t         AddrOdd   = 64'h8000_0000_0000_0001;
	localparam int                 IdlePct   = 23;
	localparam int                 Phases    = 6;
	localparam int                 PhaseLen  = 250;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	// sched_at, access_latency, address, zero fill
	logic [InDataW-1:0]  s_axis_tdata;
	// operation
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// alloc_at, ready_time, zero fill
	logic [OutDataW-1:0] m_axis_tdata;
	// forwarded
	logic                m_axis_tuser;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CycW-1:0]     cfg_wdata;

	// predictor copy of the queues and settings
	lsqt_time_t      load_release [LoadDepth];
	int              load_slot;
	lsqt_time_t      store_release [StoreDepth];
	lsqt_addr_t      store_addr [StoreDepth];
	bit              store_live [StoreDepth];
	int              store_slot;
	bit              spec_loads;
	bit              multi_rfos;
	logic [CycW-1:0] cycle_len;

	access_timing_t  owed_timings[$];
	stim_row_t       opening_rows[$];
	stim_row_t       closing_rows[$];
	lsqt_addr_t      hot_addrs [6];
	bit              steady_run = 1'b0;
	int              mismatch_count = 0;
	int              load_count = 0;
	int              store_count = 0;
	int              forward_count = 0;
	int              write_count = 0;

	load_store_queue_timing dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// overall time limit
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// time sum clamped at the largest time
	function automatic lsqt_time_t capped_sum(input lsqt_time_t a, input lsqt_time_t b);
		logic [TimeW:0] total;
		total = {1'b0, a} + {1'b0, b};
		return total[TimeW] ? TimeCeil : total[TimeW-1:0];
	endfunction

	function automatic lsqt_time_t later_of(input lsqt_time_t a, input lsqt_time_t b);
		return (a > b) ? a : b;
	endfunction

	// timing of one accepted access, updating the predicted queues
	function automatic access_timing_t time_access(input access_op_t op, input lsqt_time_t sched,
			input logic [LatW-1:0] lat_in, input lsqt_addr_t addr);
		access_timing_t res;
		lsqt_time_t     cyc;
		lsqt_time_t     lat;
		lsqt_time_t     prev_rel;
		lsqt_time_t     last_load;
		lsqt_time_t     rel;
		bit             hit;
		int             cur;
		int             prev;
		cyc = lsqt_time_t'(cycle_len);
		lat = capped_sum(lsqt_time_t'(lat_in), cyc);
		res = '0;
		if (op == OP_LOAD) begin
			// store queue lookup: same address, still held at the schedule time
			hit = 1'b0;
			foreach (store_live[i])
				if (store_live[i] && store_addr[i] == addr && store_release[i] >= sched)
					hit = 1'b1;
			if (hit) begin
				res.alloc_at   = sched;
				res.ready_time = capped_sum(sched, cyc);
				res.forwarded  = 1'b1;
			end else begin
				cur = load_slot;
				prev = (cur + LoadDepth - 1) % LoadDepth;
				prev_rel = load_release[prev];
				res.alloc_at = later_of(load_release[cur], sched);
				if (spec_loads) begin
					res.ready_time = capped_sum(res.alloc_at, lat);
					rel = later_of(res.ready_time, capped_sum(prev_rel, cyc));
				end else begin
					res.ready_time = capped_sum(later_of(prev_rel, sched), lat);
					rel = res.ready_time;
				end
				load_release[cur] = rel;
				load_slot = (cur + 1) % LoadDepth;
			end
		end else begin
			// store entry, never released before the newest load
			last_load = load_release[(load_slot + LoadDepth - 1) % LoadDepth];
			cur = store_slot;
			prev = (cur + StoreDepth - 1) % StoreDepth;
			prev_rel = store_release[prev];
			res.alloc_at = later_of(store_release[cur], sched);
			if (multi_rfos)
				rel = later_of(later_of(capped_sum(res.alloc_at, lat),
					capped_sum(prev_rel, cyc)), last_load);
			else
				rel = capped_sum(later_of(later_of(sched, prev_rel), last_load), lat);
			store_release[cur] = rel;
			store_addr[cur] = addr;
			store_live[cur] = 1'b1;
			store_slot = (cur + 1) % StoreDepth;
		end
		return res;
	endfunction

	// table line builders
	function automatic stim_row_t access_row(input access_op_t op, input lsqt_time_t sched,
			input logic [LatW-1:0] lat, input lsqt_addr_t addr);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ACCESS;
		row.op = op;
		row.sched = sched;
		row.lat = lat;
		row.addr = addr;
		return row;
	endfunction

	function automatic stim_row_t typed_row(input access_op_t op, input lsqt_time_t sched,
			input logic [LatW-1:0] lat, input lsqt_addr_t addr, input lsqt_time_t alloc_t,
			input lsqt_time_t ready_t, input logic fwd);
		stim_row_t row;
		row = access_row(op, sched, lat, addr);
		row.typed = 1'b1;
		row.expected = '{alloc_at: alloc_t, ready_time: ready_t, forwarded: fwd};
		return row;
	endfunction

	function automatic stim_row_t reg_row(input logic [CfgIdxW-1:0] idx,
			input logic [CycW-1:0] val);
		stim_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// one access offered on the input side, with random idle cycles ahead of it outside the steady run
	task automatic send_access(input access_op_t op, input lsqt_time_t sched,
			input logic [LatW-1:0] lat, input lsqt_addr_t addr, input bit typed,
			input access_timing_t typed_res);
		access_timing_t predicted;
		if (!steady_run) begin
			while ($urandom_range(0, 99) < IdlePct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, addr, lat, sched};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predicted = time_access(op, sched, lat, addr);
		owed_timings.push_back(typed ? typed_res : predicted);
		if (op == OP_LOAD)
			load_count++;
		else
			store_count++;
	endtask

	// register write once every owed result has come back
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CycW-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (owed_timings.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SPEC_LOADS: spec_loads = val[0];
			REG_MULTI_RFOS: multi_rfos = val[0];
			REG_CYCLE_TIME: cycle_len = val;
			// any other index is ignored
			default: ;
		endcase
		write_count++;
	endtask

	task automatic run_rows(input stim_row_t rows[$]);
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG)
				write_reg(rows[i].reg_idx, rows[i].reg_val);
			else
				send_access(rows[i].op, rows[i].sched, rows[i].lat, rows[i].addr,
					rows[i].typed, rows[i].expected);
		end
	endtask

	// output side stalls
	always @(posedge clk) begin
		m_axis_tready <= steady_run || ($urandom_range(0, 99) >= IdlePct);
	end

	// compare each result with the oldest owed timing
	always @(posedge clk) begin : result_check
		access_timing_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (owed_timings.size() == 0) begin
				$error("result with no access awaiting it");
				mismatch_count++;
			end else begin
				want = owed_timings.pop_front();
				if (want.forwarded)
					forward_count++;
				if (m_axis_tdata[TimeW-1:0] !== want.alloc_at) begin
					$error("alloc_at: expected %0d, actual %0d",
						want.alloc_at, m_axis_tdata[TimeW-1:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[2*TimeW-1:TimeW] !== want.ready_time) begin
					$error("ready_time: expected %0d, actual %0d",
						want.ready_time, m_axis_tdata[2*TimeW-1:TimeW]);
					mismatch_count++;
				end
				if (m_axis_tuser !== want.forwarded) begin
					$error("forwarded: expected %0d, actual %0d",
						want.forwarded, m_axis_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int              item_no;
		int              roll;
		int unsigned     cyc;
		lsqt_time_t      now_mark;
		lsqt_time_t      sched;
		logic [LatW-1:0] lat;
		lsqt_addr_t      addr;
		access_op_t      op;
		bit              spec_pick;
		bit              rfos_pick;
		logic [CycW-1:0] cycle_pick;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;

		// predictor at reset
		foreach (load_release[i])
			load_release[i] = '0;
		foreach (store_release[i]) begin
			store_release[i] = '0;
			store_addr[i] = '0;
			store_live[i] = 1'b0;
		end
		load_slot = 0;
		store_slot = 0;
		spec_loads = 1'b0;
		multi_rfos = 1'b0;
		cycle_len = CycleTimeReset;
		foreach (hot_addrs[i])
			hot_addrs[i] = {$urandom, $urandom};

		// reset values, forwarding edges, zero and largest cycle time, ignored index
		opening_rows = {
			typed_row(OP_LOAD, 0, 0, AddrLow, 0, 1000, 1'b0),
			typed_row(OP_STORE, 0, 0, AddrHigh, 0, 0, 1'b0),
			typed_row(OP_LOAD, 5, 0, AddrHigh, 5, 1005, 1'b1),
			typed_row(OP_LOAD, 2000, 0, AddrHigh, 2000, 3000, 1'b1),
			access_row(OP_LOAD, 2001, 0, AddrHigh),
			access_row(OP_LOAD, 40, 32'hFFFF_FFFF, AddrLow),
			access_row(OP_STORE, 100, 0, AddrLow),
			typed_row(OP_LOAD, 100, 0, AddrLow, 100, 1100, 1'b1),
			reg_row(REG_SPEC_LOADS, 1),
			reg_row(REG_MULTI_RFOS, 1),
			reg_row(REG_CYCLE_TIME, 0),
			access_row(OP_LOAD, 10, 7, AddrMix),
			access_row(OP_STORE, 10, 3, AddrMix),
			typed_row(OP_LOAD, 10, 0, AddrMix, 10, 10, 1'b1),
			reg_row(RegUnused, '1),
			typed_row(OP_LOAD, 11, 0, AddrMix, 11, 11, 1'b1),
			reg_row(REG_CYCLE_TIME, 1000000),
			reg_row(REG_SPEC_LOADS, 0),
			access_row(OP_STORE, 63'h3_0000_0000, 12, AddrMix),
			access_row(OP_LOAD, 3000, 1, ~AddrMix),
			access_row(OP_LOAD, 3000, 1, AddrMix),
			reg_row(REG_CYCLE_TIME, '1),
			reg_row(REG_MULTI_RFOS, 0),
			access_row(OP_STORE, 5, 32'h8000_0000, AddrOdd),
			access_row(OP_LOAD, 6, 1, AddrOdd),
			reg_row(REG_CYCLE_TIME, 1),
			access_row(OP_STORE, 7, 2, AddrLow),
			access_row(OP_LOAD, 7, 0, AddrLow)
		};

		// clamped times, kept to the end as they hold the queues at the ceiling
		closing_rows = {
			reg_row(REG_SPEC_LOADS, 1),
			reg_row(REG_MULTI_RFOS, 1),
			reg_row(REG_CYCLE_TIME, 1000),
			typed_row(OP_LOAD, TimeCeil, '1, AddrHigh, TimeCeil, TimeCeil, 1'b0),
			typed_row(OP_STORE, TimeCeil, 5, AddrHigh, TimeCeil, 0, 1'b0),
			typed_row(OP_LOAD, TimeCeil, 0, AddrHigh, TimeCeil, TimeCeil, 1'b1),
			reg_row(REG_SPEC_LOADS, 0),
			reg_row(REG_MULTI_RFOS, 0),
			access_row(OP_LOAD, 1, 0, AddrLow),
			access_row(OP_STORE, 1, 0, AddrLow),
			access_row(OP_LOAD, 2, 9, AddrMix)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_rows(opening_rows);

		// random phases, each under its own register setting
		now_mark = 10000;
		item_no = 0;
		for (int phase = 0; phase < Phases; phase++) begin
			case (phase)
				0: begin spec_pick = 0; rfos_pick = 0; cycle_pick = 1000; end
				1: begin spec_pick = 1; rfos_pick = 1; cycle_pick = 1; end
				2: begin spec_pick = 1; rfos_pick = 0; cycle_pick = 1000000; end
				3: begin spec_pick = 0; rfos_pick = 1; cycle_pick = 0; end
				4: begin spec_pick = 1; rfos_pick = 1; cycle_pick = '1; end
				default: begin
					spec_pick = 1'($urandom_range(0, 1));
					rfos_pick = 1'($urandom_range(0, 1));
					cycle_pick = CycW'($urandom_range(1, 1000000));
				end
			endcase
			write_reg(REG_SPEC_LOADS, CycW'(spec_pick));
			write_reg(REG_MULTI_RFOS, CycW'(rfos_pick));
			write_reg(REG_CYCLE_TIME, cycle_pick);
			cyc = cycle_pick;
			for (int n = 0; n < PhaseLen; n++) begin
				steady_run = (item_no >= 600 && item_no < 850);
				// time moves forward a little per access, now and then a long jump
				now_mark = now_mark + $urandom_range(0, 2 * cyc + 3);
				if ($urandom_range(0, 39) == 0)
					now_mark = now_mark + $urandom;
				sched = now_mark + $urandom_range(0, cyc);
				roll = $urandom_range(0, 99);
				if (roll < 4)
					lat = $urandom;
				else if (roll < 30)
					lat = $urandom_range(0, 200);
				else
					lat = $urandom_range(0, 4 * cyc + 16);
				// mostly a few hot addresses so that loads meet earlier stores
				if ($urandom_range(0, 99) < 85)
					addr = hot_addrs[$urandom_range(0, 5)];
				else
					addr = {$urandom, $urandom};
				op = ($urandom_range(0, 99) < 45) ? OP_STORE : OP_LOAD;
				send_access(op, sched, lat, addr, 1'b0, '0);
				item_no++;
			end
		end
		steady_run = 1'b0;

		run_rows(closing_rows);

		// drain
		s_axis_tvalid <= 1'b0;
		while (owed_timings.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d loads (%0d forwarded from stores) and %0d stores",
			load_count, forward_count, store_count);
		$display("under %0d register writes, with idle and stalled cycles on both sides",
			write_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lsqt_pkg.sv
src/lsqt_lcell.sv
src/lsqt_scell.sv
src/load_store_queue_timing.sv
src/lsqt_checker.sv
tb/sv/tb_top.sv
